// File: src/mpst_pkg.sv
// ----------------------------------------------------------------------------
// mpst_pkg
// Shared types and constants of the multi-pointer state tracker: event
// kinds, the table entry layout and the words carried on the channels.
// ----------------------------------------------------------------------------
package mpst_pkg;

  localparam int MAX_DEVICES = 8;
  localparam int BUTTON_BITS = 32;
  localparam int DEV_W       = 3;
  localparam int KIND_W      = 3;
  localparam int ITEM_W      = 5;
  localparam int DATA_W      = 32;
  localparam int COUNT_W     = 4;

  // Buttons at or beyond the mask width are never reported
  localparam logic [DATA_W-1:0] BUTTON_MASK =
    DATA_W'((33'd1 << BUTTON_BITS) - 33'd1);

  // Configuration register indexes
  localparam logic REG_DEVICE_COUNT = 1'b0;

  // Motion axes
  localparam logic [ITEM_W-1:0] AXIS_X = 5'd0;
  localparam logic [ITEM_W-1:0] AXIS_Y = 5'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK       = 3'd0,
    KIND_ABS_MOTION = 3'd1,
    KIND_REL_MOTION = 3'd2,
    KIND_BUTTON     = 3'd3,
    KIND_SCROLL     = 3'd4,
    KIND_DISCONNECT = 3'd5,
    KIND_QUERY      = 3'd6
  } kind_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DEV_W-1:0]  device;
    logic [ITEM_W-1:0] item;
    logic [DATA_W-1:0] value;
  } evt_t;

  typedef struct packed {
    logic [DATA_W-1:0] abs_x;
    logic [DATA_W-1:0] abs_y;
    logic [DATA_W-1:0] abs_z;
    logic [DATA_W-1:0] rel_x;
    logic [DATA_W-1:0] rel_y;
    logic [DATA_W-1:0] rel_z;
    logic [DATA_W-1:0] buttons;
    logic              connected;
  } entry_t;

  // Value of an entry that has never been written
  localparam entry_t ENTRY_RESET = '{
    abs_x: '0, abs_y: '0, abs_z: '0,
    rel_x: '0, rel_y: '0, rel_z: '0,
    buttons: '0, connected: 1'b1
  };

  typedef struct packed {
    logic   wr;
    entry_t nxt;
  } upd_t;

endpackage

// File: src/mpst_evt_if.sv
// ----------------------------------------------------------------------------
// mpst_evt_if
// Event channel: one word per event or query, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mpst_evt_if import mpst_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [DEV_W-1:0]         device;
  logic [ITEM_W-1:0]        item;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, kind, device, item, value, input ready);
  modport sink   (input valid, kind, device, item, value, output ready);
endinterface

// File: src/mpst_res_if.sv
// ----------------------------------------------------------------------------
// mpst_res_if
// Result channel: one word per query, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mpst_res_if import mpst_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [DEV_W-1:0]         device_out;
  logic                     valid_res;
  logic                     connected;
  logic signed [DATA_W-1:0] abs_x;
  logic signed [DATA_W-1:0] abs_y;
  logic signed [DATA_W-1:0] abs_z;
  logic signed [DATA_W-1:0] rel_x;
  logic signed [DATA_W-1:0] rel_y;
  logic signed [DATA_W-1:0] rel_z;
  logic [DATA_W-1:0]        button_mask;

  modport source (output valid, device_out, valid_res, connected, abs_x, abs_y, abs_z,
                  rel_x, rel_y, rel_z, button_mask, input ready);
  modport sink   (input valid, device_out, valid_res, connected, abs_x, abs_y, abs_z,
                  rel_x, rel_y, rel_z, button_mask, output ready);
endinterface

// File: src/mpst_update.sv
// ----------------------------------------------------------------------------
// mpst_update
// Modify step of the read-modify-write: works out the new table entry for
// one event from the entry as read, and whether it is to be written back.
// ----------------------------------------------------------------------------
module mpst_update import mpst_pkg::*; (
  input  evt_t   ev,
  input  logic   ok,
  input  entry_t cur,
  output upd_t   upd
);

  logic [DATA_W-1:0] step;
  logic [DATA_W-1:0] bit_sel;
  logic              button_ok;

  // Scroll moves one notch up for a positive amount, else one down
  assign step      = (ev.value != '0 && !ev.value[DATA_W-1]) ? DATA_W'(1) : '1;
  assign bit_sel   = DATA_W'(1) << ev.item;
  assign button_ok = {1'b0, ev.item} < (ITEM_W + 1)'(BUTTON_BITS);

  always_comb begin
    upd.wr  = 1'b0;
    upd.nxt = cur;
    if (ok) begin
      case (ev.kind)
        KIND_ABS_MOTION: begin
          if (ev.item == AXIS_X) begin
            upd.nxt.rel_x = cur.rel_x + (ev.value - cur.abs_x);
            upd.nxt.abs_x = ev.value;
            upd.wr        = 1'b1;
          end else if (ev.item == AXIS_Y) begin
            upd.nxt.rel_y = cur.rel_y + (ev.value - cur.abs_y);
            upd.nxt.abs_y = ev.value;
            upd.wr        = 1'b1;
          end
        end
        KIND_REL_MOTION: begin
          if (ev.item == AXIS_X) begin
            upd.nxt.rel_x = cur.rel_x + ev.value;
            upd.nxt.abs_x = cur.abs_x + ev.value;
            upd.wr        = 1'b1;
          end else if (ev.item == AXIS_Y) begin
            upd.nxt.rel_y = cur.rel_y + ev.value;
            upd.nxt.abs_y = cur.abs_y + ev.value;
            upd.wr        = 1'b1;
          end
        end
        KIND_BUTTON: begin
          if (button_ok) begin
            upd.nxt.buttons = (ev.value != '0) ? (cur.buttons | bit_sel)
                                               : (cur.buttons & ~bit_sel);
            upd.wr          = 1'b1;
          end
        end
        KIND_SCROLL: begin
          upd.nxt.rel_z = cur.rel_z + step;
          upd.nxt.abs_z = cur.abs_z + step;
          upd.wr        = 1'b1;
        end
        KIND_DISCONNECT: begin
          upd.nxt.connected = 1'b0;
          upd.wr            = 1'b1;
        end
        default: begin
          upd.wr = 1'b0;
        end
      endcase
    end
  end

endmodule

// File: src/multi_pointer_state_tracker.sv
// ----------------------------------------------------------------------------
// multi_pointer_state_tracker
// Table of pointing devices updated one entry per event; queries report an
// entry.
// ----------------------------------------------------------------------------
// Every event or query is handled in order: first the device's entry is
// read from the table memory, then it is modified and written back, and
// for a query the result word is loaded into the output register. The
// next word is taken once the write-back is done, so the single table port
// serves one word at a time. A query whose result finds the output
// register still full waits until it is taken. A frame tick clears the
// movement of all devices at once through per-entry flags, and the table
// needs no clearing pass after reset. Write device_count only while the block
// is idle.
// ----------------------------------------------------------------------------
module multi_pointer_state_tracker import mpst_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  mpst_evt_if.sink           evt,
  mpst_res_if.source         res
);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t               state;
  evt_t                 ev_q;
  logic [COUNT_W-1:0]   device_count;
  logic [COUNT_W-1:0]   live_count;
  logic                 ok;
  logic                 evt_acc;
  logic                 is_query;
  logic                 res_block;
  logic [MAX_DEVICES-1:0] ent_valid;
  logic [MAX_DEVICES-1:0] rel_valid;
  entry_t               mem [MAX_DEVICES];
  entry_t               rd_data;
  entry_t               cur;
  upd_t                 upd;

  logic                 res_valid;
  logic [DEV_W-1:0]     res_device;
  logic                 res_ok;
  entry_t               res_entry;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DEVICE_COUNT) ? DATA_W'(device_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_count <= '0;
    end else if (psel && penable && pwrite && paddr[2] == REG_DEVICE_COUNT) begin
      device_count <= pwdata[COUNT_W-1:0];
    end
  end

  // Clamp the count to the table depth
  assign live_count = (device_count > COUNT_W'(MAX_DEVICES)) ? COUNT_W'(MAX_DEVICES)
                                                           : device_count;
  assign ok        = COUNT_W'(ev_q.device) < live_count;
  assign evt_acc   = evt.valid && evt.ready;
  assign is_query  = ev_q.kind == KIND_QUERY;
  assign res_block = res_valid && !res.ready;
  assign evt.ready = state == S_IDLE;

  // Table memory: read on accept, write back in the execute cycle
  always_ff @(posedge clk) begin
    if (evt_acc) begin
      rd_data <= mem[evt.device];
    end
    if (state == S_EXEC && upd.wr) begin
      mem[ev_q.device] <= upd.nxt;
    end
  end

  // Entry flags: unwritten entries read as reset, cleared movement as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
      rel_valid <= '0;
    end else if (state == S_EXEC) begin
      if (ev_q.kind == KIND_TICK) begin
        rel_valid <= '0;
      end else if (upd.wr) begin
        ent_valid[ev_q.device] <= 1'b1;
        rel_valid[ev_q.device] <= 1'b1;
      end
    end
  end

  always_comb begin
    cur = rd_data;
    if (!ent_valid[ev_q.device]) begin
      cur = ENTRY_RESET;
    end else if (!rel_valid[ev_q.device]) begin
      cur.rel_x = '0;
      cur.rel_y = '0;
      cur.rel_z = '0;
    end
  end

  mpst_update u_update (
    .ev  (ev_q),
    .ok  (ok),
    .cur (cur),
    .upd (upd)
  );

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      // Load a finished query, else drop a word once it is taken
      if (state == S_EXEC && is_query && !res_block) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (evt.valid) begin
            ev_q.kind   <= evt.kind;
            ev_q.device <= evt.device;
            ev_q.item   <= evt.item;
            ev_q.value  <= evt.value;
            state       <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (!(is_query && res_block)) begin
            state <= S_IDLE;
            if (is_query) begin
              res_device <= ev_q.device;
              res_ok     <= ok;
              res_entry  <= cur;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Drive the result word; an out-of-range device reports zeros
  assign res.valid       = res_valid;
  assign res.device_out  = res_device;
  assign res.valid_res   = res_ok;
  assign res.connected   = res_ok && res_entry.connected;
  assign res.abs_x       = res_ok ? res_entry.abs_x : '0;
  assign res.abs_y       = res_ok ? res_entry.abs_y : '0;
  assign res.abs_z       = res_ok ? res_entry.abs_z : '0;
  assign res.rel_x       = res_ok ? res_entry.rel_x : '0;
  assign res.rel_y       = res_ok ? res_entry.rel_y : '0;
  assign res.rel_z       = res_ok ? res_entry.rel_z : '0;
  assign res.button_mask = res_ok ? (res_entry.buttons & BUTTON_MASK) : '0;

  // A result appears only out of the execute cycle
  a_res_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == S_EXEC))
    else $error("result word raised outside the execute cycle");

  // An accepted word always goes to the execute cycle next
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    evt_acc |=> state == S_EXEC)
    else $error("accepted word did not reach the execute cycle");

  // A tick leaves no device with live movement
  a_tick_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && ev_q.kind == KIND_TICK) |=> rel_valid == '0)
    else $error("tick did not clear movement flags");

  // Movement is only flagged for an entry that has been written
  a_rel_in_ent: assert property (@(posedge clk) disable iff (rst)
    (rel_valid & ~ent_valid) == '0)
    else $error("movement flag set on an unwritten entry");

  // A query is not dropped while the output register is full
  a_query_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && is_query && res_block) |=> state == S_EXEC)
    else $error("stalled query left the execute cycle");

endmodule
